// ===== src/frs_pkg.sv =====
// Shared constants, codes and control/status types of the roulette selector.
package frs_pkg;

  localparam int MAX_MEMBERS = 1024;
  localparam int WEIGHT_BITS = 16;
  localparam int IDX_W       = $clog2(MAX_MEMBERS);
  localparam int CNT_W       = IDX_W + 1;
  localparam int TOT_W       = WEIGHT_BITS + IDX_W;
  localparam int FRAC_W      = 16;
  localparam int PROD_W      = FRAC_W + TOT_W;
  localparam int CMD_W       = 2;
  localparam int STAT_W      = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_SELECT = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_STERILE = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_RSVD    = 2'd3
  } stat_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic mul_en;
    logic setup;
    logic search_step;
    logic load_out;
  } frs_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic run_search;
    logic search_done;
    logic out_free;
  } frs_sts_t;

endpackage

// ===== src/fitness_roulette_selector_unit.sv =====
// Top level of the fitness-proportionate roulette selector.
//
//   channel  direction  handshake                 payload
//   in_      input      in_valid / in_ready       command, item_weight, random_fraction
//   out_     output     out_valid / out_ready     chosen_index, total_weight,
//                                                 member_count, status
//   cfg_     input      cfg_write_en              cfg_write_data (sterile threshold)
//
// Clear, append, the unused command and a select that is sterile go from accept
// through the multiply state to the result. Any other select also runs a setup step,
// one search step per probe of the sum memory and one more to see the search window
// close before its result.
// Reset (rst_n low, synchronous) empties the table and zeroes the threshold.
// A new request is accepted while a result still waits; it stalls before its
// own result until out_ready takes the older one.
module fitness_roulette_selector_unit import frs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_write_en,
  input  logic [15:0]          cfg_write_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CMD_W-1:0]     in_command,
  input  logic [15:0]          in_item_weight,
  input  logic [FRAC_W-1:0]    in_random_fraction,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [IDX_W-1:0]     out_chosen_index,
  output logic [TOT_W-1:0]     out_total_weight,
  output logic [CNT_W-1:0]     out_member_count,
  output logic [STAT_W-1:0]    out_status
);

  frs_ctl_t ctl;
  frs_sts_t sts;

  // Sequence each request
  frs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  // Table, arithmetic and result register
  frs_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctl                (ctl),
    .sts                (sts),
    .cfg_write_en       (cfg_write_en),
    .cfg_write_data     (cfg_write_data),
    .in_command         (in_command),
    .in_item_weight     (in_item_weight),
    .in_random_fraction (in_random_fraction),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_chosen_index   (out_chosen_index),
    .out_total_weight   (out_total_weight),
    .out_member_count   (out_member_count),
    .out_status         (out_status)
  );

endmodule

// ===== src/frs_ctrl.sv =====
// Controller state machine of the roulette selector.
module frs_ctrl import frs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  frs_sts_t sts,
  output frs_ctl_t ctl
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_MUL    = 5'b00010,
    S_SETUP  = 5'b00100,
    S_SEARCH = 5'b01000,
    S_RESP   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // Advance the sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  // Decode next state and datapath commands
  always_comb begin
    state_nxt       = state_r;
    ctl             = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.capture = 1'b1;
          state_nxt   = S_MUL;
        end
      end
      S_MUL: begin
        ctl.mul_en = 1'b1;
        state_nxt  = sts.run_search ? S_SETUP : S_RESP;
      end
      S_SETUP: begin
        ctl.setup = 1'b1;
        state_nxt = S_SEARCH;
      end
      S_SEARCH: begin
        ctl.search_step = 1'b1;
        if (sts.search_done) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          ctl.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== src/frs_datapath.sv =====
// Datapath of the roulette selector: sum table, totals, scaling, search, result register.
module frs_datapath import frs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  frs_ctl_t               ctl,
  output frs_sts_t               sts,
  input  logic                   cfg_write_en,
  input  logic [15:0]            cfg_write_data,
  input  logic [CMD_W-1:0]       in_command,
  input  logic [15:0]            in_item_weight,
  input  logic [FRAC_W-1:0]      in_random_fraction,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [IDX_W-1:0]       out_chosen_index,
  output logic [TOT_W-1:0]       out_total_weight,
  output logic [CNT_W-1:0]       out_member_count,
  output logic [STAT_W-1:0]      out_status
);

  logic [TOT_W-1:0]       sums_mem [MAX_MEMBERS];
  logic [TOT_W-1:0]       rdata_r;
  logic [IDX_W-1:0]       rd_addr;

  logic [15:0]            thresh_r;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [TOT_W-1:0]       total_r, total_nxt;

  cmd_t                   cmd_r;
  logic [WEIGHT_BITS-1:0] weight_r;
  logic [FRAC_W-1:0]      frac_r;
  logic [PROD_W-1:0]      prod_r;
  logic [TOT_W-1:0]       target_r;

  logic [IDX_W-1:0]       lo_r, lo_nxt, hi_r, hi_nxt, mid_r;
  logic [IDX_W:0]         mid_sum;

  logic                   sterile, full, wr_en;
  logic [IDX_W-1:0]       idx_nxt;
  stat_t                  stat_nxt;

  logic                   out_valid_r;
  logic [IDX_W-1:0]       out_idx_r;
  logic [TOT_W-1:0]       out_tot_r;
  logic [CNT_W-1:0]       out_cnt_r;
  stat_t                  out_stat_r;

  assign sterile = (count_r == '0) || (total_r <= TOT_W'(thresh_r));
  assign full    = (count_r >= CNT_W'(MAX_MEMBERS));

  assign sts.run_search  = (cmd_r == CMD_SELECT) && !sterile;
  assign sts.search_done = (lo_r >= hi_r);
  assign sts.out_free    = !out_valid_r || out_ready;

  // Hold the threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= '0;
    end else if (cfg_write_en) begin
      thresh_r <= cfg_write_data;
    end
  end

  // Capture the request, then scale the fraction by the total
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r    <= cmd_t'(in_command);
      weight_r <= in_item_weight[WEIGHT_BITS-1:0];
      frac_r   <= in_random_fraction;
    end
    if (ctl.mul_en) begin
      prod_r <= PROD_W'(frac_r) * PROD_W'(total_r);
    end
    if (ctl.setup) begin
      target_r <= prod_r[PROD_W-1:FRAC_W];
    end
  end

  // Narrow the search window and pick the next probe address
  always_comb begin
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    if (ctl.setup) begin
      lo_nxt = '0;
      hi_nxt = IDX_W'(count_r - CNT_W'(1));
    end else if (ctl.search_step && (lo_r < hi_r)) begin
      if (rdata_r <= target_r) begin
        lo_nxt = mid_r + IDX_W'(1);
      end else begin
        hi_nxt = mid_r;
      end
    end
    mid_sum = {1'b0, lo_nxt} + {1'b0, hi_nxt};
    rd_addr = mid_sum[IDX_W:1];
  end

  always_ff @(posedge clk) begin
    if (ctl.setup || ctl.search_step) begin
      lo_r  <= lo_nxt;
      hi_r  <= hi_nxt;
      mid_r <= rd_addr;
    end
  end

  // Work out the table update and the result fields
  always_comb begin
    count_nxt = count_r;
    total_nxt = total_r;
    idx_nxt   = '0;
    stat_nxt  = STAT_OK;
    wr_en     = 1'b0;
    unique case (cmd_r)
      CMD_CLEAR: begin
        count_nxt = '0;
        total_nxt = '0;
      end
      CMD_APPEND: begin
        if (full) begin
          stat_nxt = STAT_FULL;
        end else begin
          total_nxt = total_r + TOT_W'(weight_r);
          count_nxt = count_r + CNT_W'(1);
          wr_en     = 1'b1;
        end
      end
      CMD_SELECT: begin
        if (sterile) begin
          stat_nxt = STAT_STERILE;
        end else begin
          idx_nxt = lo_r;
        end
      end
      default: ;
    endcase
  end

  // Commit the table state when the result is loaded
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      total_r <= '0;
    end else if (ctl.load_out) begin
      count_r <= count_nxt;
      total_r <= total_nxt;
    end
  end

  // Store the running sum and read one probe per cycle
  always_ff @(posedge clk) begin
    if (ctl.load_out && wr_en) begin
      sums_mem[count_r[IDX_W-1:0]] <= total_nxt;
    end
    rdata_r <= sums_mem[rd_addr];
  end

  // Hold the result until the consumer takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      out_idx_r  <= idx_nxt;
      out_tot_r  <= total_nxt;
      out_cnt_r  <= count_nxt;
      out_stat_r <= stat_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_chosen_index = out_idx_r;
  assign out_total_weight = out_tot_r;
  assign out_member_count = out_cnt_r;
  assign out_status       = out_stat_r;

  // Check table bounds, search window and result slot
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_MEMBERS))
    else $error("member count above table depth");

  a_window: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.search_step |-> (lo_r <= hi_r) &&
      (hi_r < count_r[IDX_W-1:0] || count_r == CNT_W'(MAX_MEMBERS)))
    else $error("search window out of order");

  a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load_out |-> (!out_valid_r || out_ready))
    else $error("result loaded over an untaken result");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.load_out && cmd_r == CMD_CLEAR) |=> (count_r == '0) && (total_r == '0))
    else $error("clear left table state behind");

endmodule

// ===== tb/fitness_roulette_selector_unit_test.sv =====
// Self-checking testbench for the roulette selector: directed table, a full table, then random sequences.
`timescale 1ns / 1ps

module fitness_roulette_selector_unit_test;
  import frs_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int ITEM_TARGET   = 1920;
  localparam int DRAIN_CYCLES  = 40;
  localparam int REPORT_LIMIT  = 10;
  localparam int DIRECTED_ROWS = 25;

  // One result of the block, field by field.
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [TOT_W-1:0] total;
    logic [CNT_W-1:0] count;
    stat_t            status;
  } selection_t;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_t;

  // A threshold row carries the new threshold in its weight field.
  typedef struct packed {
    row_kind_t  kind;
    cmd_t       cmd;
    logic [15:0] weight;
    logic [15:0] frac;
    logic        has_exp;
    selection_t  exp;
  } row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_write_en = 1'b0;
  logic [15:0]       cfg_write_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [CMD_W-1:0]  in_command = CMD_CLEAR;
  logic [15:0]       in_item_weight = '0;
  logic [FRAC_W-1:0] in_random_fraction = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [IDX_W-1:0]  out_chosen_index;
  logic [TOT_W-1:0]  out_total_weight;
  logic [CNT_W-1:0]  out_member_count;
  logic [STAT_W-1:0] out_status;

  // Literal expectation that travels with the current request.
  logic       lit_valid = 1'b0;
  selection_t lit_result = '0;

  // Shadow of the selector: running sums, count, total and threshold.
  logic [TOT_W-1:0] sum_table [MAX_MEMBERS];
  logic [CNT_W-1:0] table_count = '0;
  logic [TOT_W-1:0] table_total = '0;
  logic [15:0]      sterile_limit = '0;

  selection_t  pending_results [$];
  int unsigned requests_sent = 0;
  int unsigned results_seen = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  bit          sender_steady = 1'b0;

  row_t directed_rows [DIRECTED_ROWS] = '{
    // empty table after reset: select is sterile
    '{ROW_ITEM, CMD_SELECT, 16'h0000, 16'h0000, 1'b1,
      '{10'd0, 26'd0, 11'd0, STAT_STERILE}},
    // unused command only reports the state
    '{ROW_ITEM, CMD_NOP, 16'hFFFF, 16'hFFFF, 1'b1, '{10'd0, 26'd0, 11'd0, STAT_OK}},
    '{ROW_ITEM, CMD_APPEND, 16'hFFFF, 16'h0000, 1'b1,
      '{10'd0, 26'd65535, 11'd1, STAT_OK}},
    '{ROW_ITEM, CMD_APPEND, 16'h0000, 16'hFFFF, 1'b1,
      '{10'd0, 26'd65535, 11'd2, STAT_OK}},
    '{ROW_ITEM, CMD_APPEND, 16'h0001, 16'h0000, 1'b0, '0},
    '{ROW_ITEM, CMD_APPEND, 16'h8000, 16'h0000, 1'b0, '0},
    '{ROW_ITEM, CMD_SELECT, 16'h0000, 16'h0000, 1'b0, '0},
    '{ROW_ITEM, CMD_SELECT, 16'h0000, 16'hFFFF, 1'b0, '0},
    '{ROW_ITEM, CMD_SELECT, 16'hFFFF, 16'h8000, 1'b0, '0},
    '{ROW_ITEM, CMD_SELECT, 16'h0000, 16'h5555, 1'b0, '0},
    '{ROW_ITEM, CMD_SELECT, 16'h0000, 16'hAAAA, 1'b0, '0},
    '{ROW_ITEM, CMD_CLEAR, 16'hFFFF, 16'hFFFF, 1'b1, '{10'd0, 26'd0, 11'd0, STAT_OK}},
    '{ROW_ITEM, CMD_SELECT, 16'h0000, 16'h8000, 1'b1,
      '{10'd0, 26'd0, 11'd0, STAT_STERILE}},
    // zero-weight member: total stays at the threshold, so select is sterile
    '{ROW_ITEM, CMD_APPEND, 16'h0000, 16'h0000, 1'b1, '{10'd0, 26'd0, 11'd1, STAT_OK}},
    '{ROW_ITEM, CMD_SELECT, 16'h0000, 16'h8000, 1'b1,
      '{10'd0, 26'd0, 11'd1, STAT_STERILE}},
    '{ROW_ITEM, CMD_APPEND, 16'h0001, 16'h0000, 1'b1, '{10'd0, 26'd1, 11'd2, STAT_OK}},
    // the zero-weight member can never win
    '{ROW_ITEM, CMD_SELECT, 16'h0000, 16'hFFFF, 1'b1, '{10'd1, 26'd1, 11'd2, STAT_OK}},
    '{ROW_CFG, CMD_NOP, 16'd100, 16'h0000, 1'b0, '0},
    '{ROW_ITEM, CMD_CLEAR, 16'h0000, 16'h0000, 1'b1, '{10'd0, 26'd0, 11'd0, STAT_OK}},
    '{ROW_ITEM, CMD_APPEND, 16'd100, 16'h0000, 1'b1, '{10'd0, 26'd100, 11'd1, STAT_OK}},
    // total equal to the threshold is sterile, one above is not
    '{ROW_ITEM, CMD_SELECT, 16'h0000, 16'h1234, 1'b1,
      '{10'd0, 26'd100, 11'd1, STAT_STERILE}},
    '{ROW_ITEM, CMD_APPEND, 16'd1, 16'h0000, 1'b1, '{10'd0, 26'd101, 11'd2, STAT_OK}},
    '{ROW_ITEM, CMD_SELECT, 16'h0000, 16'h1234, 1'b0, '0},
    '{ROW_CFG, CMD_NOP, 16'hFFFF, 16'h0000, 1'b0, '0},
    '{ROW_ITEM, CMD_SELECT, 16'h0000, 16'hFFFF, 1'b1,
      '{10'd0, 26'd101, 11'd2, STAT_STERILE}}
  };

  fitness_roulette_selector_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_write_en       (cfg_write_en),
    .cfg_write_data     (cfg_write_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_command         (in_command),
    .in_item_weight     (in_item_weight),
    .in_random_fraction (in_random_fraction),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_chosen_index   (out_chosen_index),
    .out_total_weight   (out_total_weight),
    .out_member_count   (out_member_count),
    .out_status         (out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one request to the shadow table and return the result it must give.
  function automatic selection_t roulette_predict(cmd_t cmd, logic [15:0] weight,
                                                  logic [15:0] frac);
    selection_t          res;
    logic [PROD_W-1:0]   scaled;
    logic [TOT_W-1:0]    target;
    int                  lo;
    int                  hi;
    int                  mid;
    res = '0;
    res.status = STAT_OK;
    unique case (cmd)
      CMD_CLEAR: begin
        table_count = '0;
        table_total = '0;
      end
      CMD_APPEND: begin
        if (table_count >= CNT_W'(MAX_MEMBERS)) begin
          res.status = STAT_FULL;
        end else begin
          table_total = table_total + TOT_W'(weight[WEIGHT_BITS-1:0]);
          sum_table[table_count[IDX_W-1:0]] = table_total;
          table_count = table_count + CNT_W'(1);
        end
      end
      CMD_SELECT: begin
        if (table_count == 0 || table_total <= TOT_W'(sterile_limit)) begin
          res.status = STAT_STERILE;
        end else begin
          scaled = PROD_W'(frac) * PROD_W'(table_total);
          target = TOT_W'(scaled >> FRAC_W);
          // first entry whose running sum is above the target
          lo = 0;
          hi = int'(table_count) - 1;
          while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (sum_table[IDX_W'(mid)] <= target) lo = mid + 1;
            else hi = mid;
          end
          res.idx = IDX_W'(lo);
        end
      end
      default: ;
    endcase
    res.total = table_total;
    res.count = table_count;
    return res;
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic compare_result(input selection_t exp);
    if (out_chosen_index !== exp.idx)
      note_failure($sformatf("chosen_index expected %0d got %0d", exp.idx, out_chosen_index));
    if (out_total_weight !== exp.total)
      note_failure($sformatf("total_weight expected %0d got %0d", exp.total,
                             out_total_weight));
    if (out_member_count !== exp.count)
      note_failure($sformatf("member_count expected %0d got %0d", exp.count,
                             out_member_count));
    if (out_status !== exp.status)
      note_failure($sformatf("status expected %0d got %0d", exp.status, out_status));
  endtask

  // Predict on every accepted request, check every accepted result.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        selection_t predicted;
        predicted = roulette_predict(cmd_t'(in_command), in_item_weight, in_random_fraction);
        if (lit_valid) predicted = lit_result;
        pending_results = {pending_results, predicted};
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_results.size() == 0) note_failure("result with no request pending");
        else compare_result(pending_results.pop_front());
      end
    end
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: ready runs of random length, broken by stalls, mostly short.
  initial begin
    int run_len;
    int stall_len;
    int pick;
    forever begin
      pick = $urandom_range(99);
      if (pick < 70) run_len = $urandom_range(8, 1);
      else if (pick < 95) run_len = $urandom_range(40, 9);
      else run_len = $urandom_range(300, 100);
      out_ready <= 1'b1;
      repeat (run_len) @(negedge clk);
      pick = $urandom_range(99);
      if (pick < 70) stall_len = $urandom_range(2, 1);
      else if (pick < 95) stall_len = $urandom_range(8, 3);
      else stall_len = $urandom_range(50, 20);
      out_ready <= 1'b0;
      repeat (stall_len) @(negedge clk);
    end
  end

  function automatic int pick_gap();
    int pick;
    pick = $urandom_range(99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(3, 1);
    if (pick < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [15:0] pick_weight();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return 16'h0000;
    if (pick < 30) return 16'($urandom_range(16, 1));
    if (pick < 40) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_fraction();
    int pick;
    pick = $urandom_range(99);
    if (pick < 5) return 16'h0000;
    if (pick < 10) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  // Drive one request after a random gap (none while the sender is steady) and hold it until accepted.
  task automatic send_request(input cmd_t cmd, input logic [15:0] weight,
                              input logic [15:0] frac, input logic has_exp,
                              input selection_t exp);
    int gap;
    gap = sender_steady ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid           <= 1'b1;
    in_command         <= cmd;
    in_item_weight     <= weight;
    in_random_fraction <= frac;
    lit_valid          <= has_exp;
    lit_result         <= exp;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
  endtask

  // Drop valid and hold off until every result has come back.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_seen < requests_sent) @(negedge clk);
  endtask

  task automatic set_threshold(input logic [15:0] value);
    wait_idle();
    @(negedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    @(negedge clk);
    cfg_write_en  <= 1'b0;
    sterile_limit  = value;
  endtask

  function automatic logic [15:0] pick_threshold();
    int pick;
    pick = $urandom_range(99);
    if (pick < 30) return 16'h0000;
    if (pick < 45) return 16'hFFFF;
    if (pick < 70) return 16'($urandom_range(512));
    return 16'($urandom);
  endfunction

  // Clear, fill with random weights, then select with random fractions and the odd append.
  task automatic run_sequence();
    int members;
    members = ($urandom_range(3) == 0) ? $urandom_range(3, 1) : $urandom_range(40, 1);
    send_request(CMD_CLEAR, 16'($urandom), 16'($urandom), 1'b0, '0);
    repeat (members) send_request(CMD_APPEND, pick_weight(), 16'($urandom), 1'b0, '0);
    repeat ($urandom_range(12, 1)) begin
      if ($urandom_range(4) == 0)
        send_request(CMD_APPEND, pick_weight(), 16'($urandom), 1'b0, '0);
      send_request(CMD_SELECT, 16'($urandom), pick_fraction(), 1'b0, '0);
    end
  endtask

  task automatic run_noise();
    repeat ($urandom_range(10, 1))
      send_request(cmd_t'($urandom_range(3)), 16'($urandom), 16'($urandom), 1'b0, '0);
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Walk the directed table.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        set_threshold(directed_rows[i].weight);
      end else begin
        send_request(directed_rows[i].cmd, directed_rows[i].weight, directed_rows[i].frac,
                     directed_rows[i].has_exp, directed_rows[i].exp);
      end
    end

    // Fill the table to the top with maximum weights, then push past it.
    set_threshold(16'($urandom));
    send_request(CMD_CLEAR, 16'h0000, 16'h0000, 1'b0, '0);
    repeat (MAX_MEMBERS) send_request(CMD_APPEND, 16'hFFFF, 16'($urandom), 1'b0, '0);
    repeat (3) send_request(CMD_APPEND, 16'($urandom), 16'($urandom), 1'b0, '0);
    send_request(CMD_SELECT, 16'($urandom), 16'h0000, 1'b0, '0);
    send_request(CMD_SELECT, 16'($urandom), 16'hFFFF, 1'b0, '0);
    repeat (10) send_request(CMD_SELECT, 16'($urandom), 16'($urandom), 1'b0, '0);
    send_request(CMD_NOP, 16'($urandom), 16'($urandom), 1'b0, '0);

    // Random phases, each under its own threshold.
    while (requests_sent < ITEM_TARGET) begin
      set_threshold(pick_threshold());
      sender_steady = ($urandom_range(3) == 0);
      repeat ($urandom_range(3, 1)) begin
        if ($urandom_range(99) < 85) run_sequence();
        else run_noise();
      end
    end

    // Drain and report.
    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (pending_results.size() != 0)
      note_failure($sformatf("%0d results never arrived", pending_results.size()));
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
